>>> design/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths, types and defaults for the sliding window maximum filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int CFG_W          = 7;
    localparam int WINDOW_MAX_DEF = 64;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_W-1:0]           win_cfg_t;

endpackage

>>> design/swm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm channel interfaces
// Valid/ready channels for samples, results and the window size register.
// ----------------------------------------------------------------------------
interface swm_in_if;
    logic               valid;
    logic               ready;
    swm_pkg::sample_t   sample;
    logic               restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if;
    logic               valid;
    logic               ready;
    swm_pkg::sample_t   window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if;
    logic               valid;
    logic               ready;
    swm_pkg::win_cfg_t  window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

>>> design/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the max chain: holds the maximum of the last (position + 1)
// samples and hands it to its neighbour on every accepted word.
// ----------------------------------------------------------------------------
module swm_cell (
    input  logic              clk,
    input  logic              advance,
    input  swm_pkg::sample_t  sample,
    input  swm_pkg::sample_t  prev_max,
    output swm_pkg::sample_t  max_next,
    output swm_pkg::sample_t  max_q
);

    swm_pkg::sample_t max_reg;

    // newest sample against the shorter window held by the neighbour
    assign max_next = (sample > prev_max) ? sample : prev_max;
    assign max_q    = max_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            max_reg <= max_next;
        end
    end

endmodule

>>> design/sliding_window_maximum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum_top
// Running maximum over the last window_size samples, built as a chain of
// compare cells.
// ----------------------------------------------------------------------------
// Output: a result is registered and valid in the cycle after its sample is accepted.
// Throughput: one sample per cycle unless results stall; each chain cell
//   does one 32-bit compare per word; the result register frees once taken.
// Reset: window_size returns to 1 and the sample count to 0; cell contents
//   are undefined until samples have shifted through them.
// ----------------------------------------------------------------------------
module sliding_window_maximum_top #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    swm_cfg_if.sink   cfg,
    swm_in_if.sink    samples,
    swm_out_if.source results
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW    = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;

    logic [CNT_W-1:0] win_reg,  win_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic             out_valid_reg, out_valid_next;
    swm_pkg::sample_t out_data_reg;

    swm_pkg::sample_t cell_next [WINDOW_MAX];
    swm_pkg::sample_t cell_q    [WINDOW_MAX];

    logic             accept;
    logic [KW-1:0]    cfg_ext;
    logic [IDX_W-1:0] tap;

    assign cfg.ready     = 1'b1;
    assign samples.ready = !out_valid_reg || results.ready;
    assign accept        = samples.valid && samples.ready;

    // clamp the written window into 1..WINDOW_MAX
    assign cfg_ext = KW'(cfg.window_size);
    always_comb
    begin
        win_next = win_reg;
        if (cfg.valid)
        begin
            if (cfg_ext == '0)
                win_next = CNT_W'(1);
            else if (cfg_ext > KW'(WINDOW_MAX))
                win_next = CNT_W'(WINDOW_MAX);
            else
                win_next = CNT_W'(cfg_ext);
        end
    end

    always_comb
    begin
        if (samples.restart)
            seen_next = CNT_W'(1);
        else if (seen_reg == CNT_W'(WINDOW_MAX))
            seen_next = seen_reg;
        else
            seen_next = seen_reg + CNT_W'(1);
    end

    genvar g;
    generate
        for (g = 0; g < WINDOW_MAX; g++)
        begin : g_cell
            swm_cell u_cell (
                .clk      (clk),
                .advance  (accept),
                .sample   (samples.sample),
                .prev_max ((g == 0) ? samples.sample : cell_q[(g == 0) ? 0 : g - 1]),
                .max_next (cell_next[g]),
                .max_q    (cell_q[g])
            );
        end
    endgenerate

    assign tap = IDX_W'(win_reg - CNT_W'(1));

    always_comb
    begin
        out_valid_next = out_valid_reg && !results.ready;
        if (accept)
            out_valid_next = (seen_next >= win_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= CNT_W'(1);
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                seen_reg <= seen_next;
            end
        end
    end

    // hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= cell_next[tap];
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.window_max = out_data_reg;

endmodule

>>> design/swm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks on the sliding window maximum filter, bound to the top.
// ----------------------------------------------------------------------------
module swm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input swm_pkg::sample_t window_max
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(window_max))
        else $error("result word changed while stalled");

    // results appear only after a sample was taken
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared without an accepted sample");

    // an empty result register never blocks the input
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no pending result");

    // a taken result with no new sample leaves the output empty
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
        else $error("result repeated");

endmodule

bind sliding_window_maximum_top swm_checker u_swm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .window_max (results.window_max)
);
